[rtl/wai_pkg.sv]
// wai_pkg: shared types and fixed field widths of the window average interval keeper
// no dependencies; imported by wai_ring and window_average_interval_keeper
`default_nettype none

package wai_pkg;

  // fixed field widths
  localparam int VALUE_W    = 32;
  localparam int AVG_W      = 32;
  localparam int WIN_W      = 9;
  localparam int OUT_W      = 42;
  localparam int BUDGET_W   = AVG_W + WIN_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int WIN_MIN = 2;
  localparam logic [WIN_W-1:0] WIN_RESET = 9'd257;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN   = 1'b1;

  // item kinds; the fourth code is ignored
  typedef enum logic [1:0] {
    KIND_PULSE = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

endpackage

`default_nettype wire

[rtl/wai_ring.sv]
// wai_ring: ring of recent pulse lengths with write pointer, fill mark and pulse count
// uses wai_pkg; instantiated by window_average_interval_keeper
`default_nettype none

module wai_ring #(
  parameter int RING_DEPTH   = 256,
  parameter int LENGTH_WIDTH = 32
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           acc,
  input  wai_pkg::kind_t                kind,
  input  wire        [LENGTH_WIDTH-1:0] len,
  input  wire        [wai_pkg::WIN_W-1:0] slots,
  output logic       [LENGTH_WIDTH-1:0] old_len,
  output logic                          full
);
  import wai_pkg::*;

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int HW_W  = PTR_W + 1;
  localparam int CW    = (HW_W > WIN_W) ? HW_W : WIN_W;

  logic [LENGTH_WIDTH-1:0] mem [RING_DEPTH];
  logic [LENGTH_WIDTH-1:0] rdata_r;
  logic                    old_valid_r;
  logic                    full_r;
  logic [PTR_W-1:0]        ptr_r, ptr_nxt;
  logic [HW_W-1:0]         hw_r, hw_nxt;
  logic [WIN_W-1:0]        count_r, count_nxt;
  logic [PTR_W-1:0]        p;
  logic [CW-1:0]           p_inc;
  logic                    do_pulse;

  assign do_pulse = acc && (kind == KIND_PULSE);

  // pointer left beyond a shrunken ring restarts at entry 0
  assign p     = (CW'(ptr_r) >= CW'(slots)) ? '0 : ptr_r;
  assign p_inc = CW'(p) + CW'(1);

  always_comb begin
    ptr_nxt   = ptr_r;
    hw_nxt    = hw_r;
    count_nxt = count_r;
    if (acc) begin
      case (kind)
        KIND_PULSE: begin
          ptr_nxt = (p_inc >= CW'(slots)) ? '0 : PTR_W'(p_inc);
          // entries written since the last clear always form a prefix
          if (HW_W'(p) == hw_r) hw_nxt = hw_r + HW_W'(1);
          if (count_r < slots) count_nxt = count_r + WIN_W'(1);
        end
        KIND_CLEAR: begin
          ptr_nxt   = '0;
          hw_nxt    = '0;
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      hw_r    <= '0;
      count_r <= '0;
    end else begin
      ptr_r   <= ptr_nxt;
      hw_r    <= hw_nxt;
      count_r <= count_nxt;
    end
  end

  // read before write at the same entry
  always_ff @(posedge clk) begin
    if (do_pulse) begin
      mem[p] <= len;
    end
    if (acc) begin
      rdata_r     <= mem[p];
      old_valid_r <= HW_W'(p) < hw_r;
      full_r      <= count_r >= slots;
    end
  end

  assign old_len = old_valid_r ? rdata_r : '0;
  assign full    = full_r;

`ifndef ASSERT_OFF
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(ptr_r) < RING_DEPTH)
    else $error("ring pointer beyond ring depth");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(hw_r) <= RING_DEPTH)
    else $error("fill mark beyond ring depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind == KIND_CLEAR |=> hw_r == '0 && count_r == '0 && ptr_r == '0)
    else $error("clear item left ring history");
`endif

endmodule

`default_nettype wire

[rtl/window_average_interval_keeper.sv]
// window_average_interval_keeper: average pulse interval keeper, top level
// uses wai_pkg and wai_ring
//
// usage:
//   in_kind/in_value items are taken when in_valid is high and in_stall low.
//   a pulse item records its length, a clear item empties the history, a
//   query item returns one out_min_interval item, taken when out_valid is
//   high and out_stall low. pulse, clear and the unused kind give no result.
//   cfg_index/cfg_data write avg_interval (0) and window_len (1). cfg_ready is
//   always high; make writes only while no item is in flight (not enforced).
// timing:
//   one item per cycle while in_stall is low. the ring is read and written at
//   the accept edge, the running total and the query answer are settled in
//   the next cycle and the answer is registered as the query leaves the stage.
// stall:
//   a pending result waits in the output register; pulses and clears keep
//   flowing, and in_stall rises only when a query is ready behind a stalled
//   result.
// reset:
//   synchronous, active low; history empty, avg_interval 0, window_len 257.
//   the ring holds a fill mark, so no clearing pass is needed.
`default_nettype none

module window_average_interval_keeper #(
  parameter int RING_DEPTH   = 256,
  parameter int LENGTH_WIDTH = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire        [1:0]                  in_kind,
  input  wire        [wai_pkg::VALUE_W-1:0] in_value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic       [wai_pkg::OUT_W-1:0]   out_min_interval,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire        [wai_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire        [wai_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wai_pkg::*;

  localparam int TOTAL_W = LENGTH_WIDTH + $clog2(RING_DEPTH + 1);
  localparam int CMP_W   = (TOTAL_W > BUDGET_W) ? TOTAL_W : BUDGET_W;
  localparam int WIN_MAX = RING_DEPTH + 1;

  logic [AVG_W-1:0]        avg_r;
  logic [WIN_W-1:0]        wlen_r;
  logic [WIN_W-1:0]        w_eff;
  logic [WIN_W-1:0]        slots;
  logic [BUDGET_W-1:0]     budget_r;

  logic                    in_acc;
  logic                    s1_valid_r;
  kind_t                   s1_kind_r;
  logic [VALUE_W-1:0]      s1_value_r;
  logic                    s1_go;

  logic [LENGTH_WIDTH-1:0] old_len;
  logic                    full;
  logic [TOTAL_W-1:0]      total_r, total_nxt;

  logic [VALUE_W-1:0]      req_m;
  logic [CMP_W-1:0]        tot_ext, bud_ext, diff, res_sel;

  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_min_interval_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r  <= '0;
      wlen_r <= WIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AVG_INTERVAL: avg_r  <= cfg_data[AVG_W-1:0];
        CFG_WINDOW_LEN:   wlen_r <= cfg_data[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (wlen_r < WIN_W'(WIN_MIN)) begin
      w_eff = WIN_W'(WIN_MIN);
    end else if (32'(wlen_r) > 32'(WIN_MAX)) begin
      w_eff = WIN_W'(WIN_MAX);
    end else begin
      w_eff = wlen_r;
    end
  end

  assign slots = w_eff - WIN_W'(1);

  // budget is registered from the configuration registers
  always_ff @(posedge clk) begin
    budget_r <= BUDGET_W'(avg_r) * BUDGET_W'(w_eff);
  end

  // input handshake and working stage
  assign s1_go    = (s1_kind_r != KIND_QUERY) || !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r  <= kind_t'(in_kind);
      s1_value_r <= in_value;
    end
  end

  wai_ring #(
    .RING_DEPTH  (RING_DEPTH),
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (in_acc),
    .kind   (kind_t'(in_kind)),
    .len    (LENGTH_WIDTH'(in_value)),
    .slots  (slots),
    .old_len(old_len),
    .full   (full)
  );

  // running total of the ring
  always_comb begin
    total_nxt = total_r;
    if (s1_valid_r && s1_go) begin
      case (s1_kind_r)
        KIND_PULSE: total_nxt = total_r - TOTAL_W'(old_len)
                                + TOTAL_W'(LENGTH_WIDTH'(s1_value_r));
        KIND_CLEAR: total_nxt = '0;
        default:    total_nxt = total_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  // query answer
  assign req_m   = (s1_value_r == '0) ? VALUE_W'(1) : s1_value_r;
  assign tot_ext = CMP_W'(total_r);
  assign bud_ext = CMP_W'(budget_r);
  assign diff    = bud_ext - tot_ext;

  always_comb begin
    if (!full || tot_ext >= bud_ext) begin
      res_sel = CMP_W'(req_m);
    end else if (diff > CMP_W'(req_m)) begin
      res_sel = diff;
    end else begin
      res_sel = CMP_W'(req_m);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_kind_r == KIND_QUERY && s1_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_kind_r == KIND_QUERY && s1_go) begin
      out_min_interval_r <= OUT_W'(res_sel);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_min_interval = out_min_interval_r;

`ifndef ASSERT_OFF
  a_clear_total: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_kind_r == KIND_CLEAR |=> total_r == '0)
    else $error("running total not cleared");

  a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_min_interval_r != '0)
    else $error("zero interval returned");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_kind_r == KIND_QUERY && out_valid_r && out_stall)
    else $error("input stalled without a blocked query");

  a_query_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_kind_r == KIND_QUERY && s1_go |=> out_valid_r)
    else $error("query result lost");
`endif

endmodule

`default_nettype wire
